// ===== src/assert_macros.svh =====
// Assertion helpers for the top-level RTL. Clock is clk, reset is rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/ifp_pkg.sv =====
package ifp_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int QIDX_W  = 3;
    localparam int POS_W   = 9;
    localparam int LEFT_W  = 4;

    // Frame header and marker bytes
    localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'hFA;
    localparam logic [BYTE_W-1:0] BUS_ID_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] DATA_MSG_ID   = 8'h36;
    localparam logic [BYTE_W-1:0] ANGLE_MARK    = 8'h0C;

    localparam logic [LEFT_W-1:0] WORD_BYTES_TOTAL = 4'd12;
    localparam logic [7:0]        LENGTH_RESET     = 8'd5;

    // Header progress codes
    localparam logic [1:0] HDR_PREAMBLE_SEEN = 2'd2;
    localparam logic [1:0] HDR_DONE          = 2'd3;

    // Byte positions within a frame
    localparam logic [POS_W-1:0] POS_PREAMBLE   = 9'd1;
    localparam logic [POS_W-1:0] POS_BUS_ID     = 9'd2;
    localparam logic [POS_W-1:0] POS_MSG_ID     = 9'd3;
    localparam logic [POS_W-1:0] POS_LENGTH     = 9'd4;
    localparam logic [POS_W-1:0] POS_ANGLE_MARK = 9'd7;
    localparam logic [POS_W-1:0] POS_ANGLE_DATA = 9'd8;
    localparam logic [POS_W-1:0] POS_ACCEL_DATA = 9'd23;
    localparam logic [POS_W-1:0] FRAME_OVERHEAD = 9'd4;

    // Quantity indexes
    localparam logic [QIDX_W-1:0] QIDX_ANGLE_Z = 3'd2;
    localparam logic [QIDX_W-1:0] QIDX_ACCEL_Z = 3'd5;

    typedef struct packed {
        logic                valid;
        logic [QIDX_W-1:0]   quantity_index;
        logic [WORD_W-1:0]   value_bits;
        logic                last_of_frame;
    } parse_result_t;

endpackage

// ===== src/ifp_input_stage.sv =====
module ifp_input_stage
    import ifp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              take,
    output logic              item_valid,
    output logic [BYTE_W-1:0] item_byte
);

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    // Accept a new request when empty or when the held byte leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Hold the byte until it is consumed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

// ===== src/ifp_parse_core.sv =====
module ifp_parse_core
    import ifp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [BYTE_W-1:0] item_byte,
    input  logic              out_free,
    output logic              take,
    output parse_result_t     result
);

    logic [POS_W-1:0]  pos_reg, pos_next, pos_inc;
    logic [1:0]        hdr_reg, hdr_next;
    logic [BYTE_W-1:0] msg_reg, msg_next;
    logic [7:0]        len_reg, len_next;
    logic [LEFT_W-1:0] ang_reg, ang_next, ang_cur, ang_dec;
    logic [LEFT_W-1:0] acc_reg, acc_next, acc_dec;
    logic [WORD_W-1:0] wa_reg, wa_next, wa_work, wa_shift;
    logic              emit;
    logic              restart;
    logic [QIDX_W-1:0] idx;
    logic [WORD_W-1:0] val;

    // Decode one byte against the frame state
    always_comb
    begin
        pos_inc  = pos_reg + 9'd1;
        hdr_next = hdr_reg;
        msg_next = msg_reg;
        len_next = len_reg;
        ang_cur  = ang_reg;
        ang_dec  = ang_reg;
        ang_next = ang_reg;
        acc_dec  = acc_reg;
        acc_next = acc_reg;
        wa_work  = wa_reg;
        wa_shift = wa_reg;
        wa_next  = wa_reg;
        emit     = 1'b0;
        restart  = 1'b0;
        idx      = '0;
        val      = '0;

        priority if (item_byte == PREAMBLE_BYTE && pos_inc == POS_PREAMBLE)
        begin
            hdr_next = hdr_reg + 2'd1;
        end
        else if (item_byte == BUS_ID_BYTE && pos_inc == POS_BUS_ID)
        begin
            hdr_next = hdr_reg + 2'd1;
        end
        else if (pos_inc == POS_MSG_ID && hdr_reg == HDR_PREAMBLE_SEEN)
        begin
            hdr_next = HDR_DONE;
            msg_next = item_byte;
        end
        else if (hdr_reg == HDR_DONE && msg_reg == DATA_MSG_ID)
        begin
            if (pos_inc == POS_LENGTH)
            begin
                len_next = item_byte;
            end
            if (pos_inc == POS_ANGLE_MARK && item_byte == ANGLE_MARK)
            begin
                ang_cur = WORD_BYTES_TOTAL;
            end
            ang_next = ang_cur;

            // Shift in an angle byte
            if (ang_cur != '0 && pos_inc >= POS_ANGLE_DATA)
            begin
                wa_shift = {wa_reg[WORD_W-BYTE_W-1:0], item_byte};
                ang_dec  = ang_cur - 4'd1;
                ang_next = ang_dec;
                if (ang_dec[1:0] == 2'd0)
                begin
                    emit    = 1'b1;
                    idx     = QIDX_ANGLE_Z - {1'b0, ang_dec[3:2]};
                    val     = wa_shift;
                    wa_work = '0;
                    if (ang_dec == '0)
                    begin
                        acc_next = WORD_BYTES_TOTAL;
                    end
                end
                else
                begin
                    wa_work = wa_shift;
                end
            end
            wa_next = wa_work;

            // Shift in an acceleration byte
            if (!emit && pos_inc >= POS_ACCEL_DATA && acc_reg != '0)
            begin
                acc_dec  = acc_reg - 4'd1;
                acc_next = acc_dec;
                if (acc_dec[1:0] == 2'd0)
                begin
                    emit    = 1'b1;
                    idx     = QIDX_ACCEL_Z - {1'b0, acc_dec[3:2]};
                    val     = {wa_work[WORD_W-BYTE_W-1:0], item_byte};
                    wa_next = '0;
                end
                else
                begin
                    wa_next = {wa_work[WORD_W-BYTE_W-1:0], item_byte};
                end
            end
        end
        else
        begin
            restart = 1'b1;
        end

        // End of frame uses the length as updated by this byte
        if (pos_inc == {1'b0, len_next} + FRAME_OVERHEAD)
        begin
            restart = 1'b1;
        end

        if (restart)
        begin
            pos_next = '0;
            hdr_next = '0;
            ang_next = '0;
            acc_next = '0;
            wa_next  = '0;
        end
        else
        begin
            pos_next = pos_inc;
        end
    end

    // Consume the byte unless its word has nowhere to go
    assign take = item_valid && (!emit || out_free);

    assign result.valid          = item_valid && emit;
    assign result.quantity_index = idx;
    assign result.value_bits     = val;
    assign result.last_of_frame  = (idx == QIDX_ACCEL_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hdr_reg <= '0;
            msg_reg <= '0;
            len_reg <= LENGTH_RESET;
            ang_reg <= '0;
            acc_reg <= '0;
            wa_reg  <= '0;
        end
        else if (take)
        begin
            pos_reg <= pos_next;
            hdr_reg <= hdr_next;
            msg_reg <= msg_next;
            len_reg <= len_next;
            ang_reg <= ang_next;
            acc_reg <= acc_next;
            wa_reg  <= wa_next;
        end
    end

endmodule

// ===== src/ifp_output_stage.sv =====
module ifp_output_stage
    import ifp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  parse_result_t     result,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [QIDX_W-1:0] quantity_index,
    output logic [WORD_W-1:0] value_bits,
    output logic              last_of_frame
);

    logic              valid_reg;
    logic [QIDX_W-1:0] qidx_reg;
    logic [WORD_W-1:0] value_reg;
    logic              last_reg;

    // Slot frees when empty or when the held word is taken this cycle
    assign out_free       = !valid_reg || out_ready;
    assign out_valid      = valid_reg;
    assign quantity_index = qidx_reg;
    assign value_bits     = value_reg;
    assign last_of_frame  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture the finished word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            qidx_reg  <= result.quantity_index;
            value_reg <= result.value_bits;
            last_reg  <= result.last_of_frame;
        end
    end

endmodule

// ===== src/imu_frame_receive_parser_top.sv =====
// Receive-side parser for an inertial sensor data frame.
// Input channel (in_valid/in_ready/rx_byte): one received link byte per request.
// Output channel (out_valid/out_ready): one request per finished 32-bit word,
// with quantity_index 0..2 for angle x,y,z and 3..5 for acceleration x,y,z,
// value_bits as the raw big-endian bit pattern and last_of_frame on the
// acceleration z word. Bytes that finish no word produce no output request.
// Path: a byte accepted into the input register is decoded and, if it finishes
// a word, is loaded into the output register, which drives out_valid.
// Throughput: one byte per cycle, set by the single decode step between the
// input and output registers, unless a word-finishing byte waits (see Stall).
// Stall: while the output register holds an untaken word, bytes that finish
// no word still pass; a byte that finishes a word waits in the input register
// and in_ready drops until out_ready frees the slot.
// Reset: both registers empty, byte position and header cleared, message id 0,
// payload length 5.
module imu_frame_receive_parser_top
    import ifp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [QIDX_W-1:0] quantity_index,
    output logic [WORD_W-1:0] value_bits,
    output logic              last_of_frame
);

    `include "assert_macros.svh"

    logic              item_valid;
    logic [BYTE_W-1:0] item_byte;
    logic              core_take;
    logic              out_free;
    parse_result_t     core_result;

    ifp_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .take       (core_take),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    ifp_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .out_free   (out_free),
        .take       (core_take),
        .result     (core_result)
    );

    ifp_output_stage u_output (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (core_take && core_result.valid),
        .result         (core_result),
        .out_free       (out_free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .quantity_index (quantity_index),
        .value_bits     (value_bits),
        .last_of_frame  (last_of_frame)
    );

    // Last flag only on the acceleration z word
    `ASSERT_IMPLIES(a_last_is_accel_z, out_valid && last_of_frame, quantity_index == QIDX_ACCEL_Z)
    // Index stays within the six quantities
    `ASSERT_IMPLIES(a_index_range, out_valid, quantity_index <= QIDX_ACCEL_Z)
    // A word is consumed from the core only when the output slot is free
    `ASSERT_IMPLIES(a_no_overwrite, core_take && core_result.valid, out_free)
    // A consumed word shows up on the output next cycle
    `ASSERT_NEXT(a_word_loaded, core_take && core_result.valid, out_valid && value_bits == $past(core_result.value_bits))

endmodule
